// File: rtl/asmp_pkg.sv
// ----------------------------------------------------------------------------
// asmp_pkg
// Shared types, constants and tables of the arctangent servo motion profile.
// ----------------------------------------------------------------------------
package asmp_pkg;

   localparam int STEP_MS_DEF      = 5;
   localparam int CORDIC_STEPS_DEF = 24;

   localparam int ANGLE_W = 8;
   localparam int DUR_W   = 16;
   localparam int GAIN_W  = 32;
   localparam int DATA_W  = 32;
   localparam int IDX_W   = 3;
   localparam int T_W     = 17;
   localparam int DIFF_W  = 20;
   localparam int PROD_W  = 52;
   localparam int Y_W     = 54;
   localparam int Z_W     = 33;
   localparam int ITER_W  = 5;
   localparam int K_W     = 17;
   localparam int NUM_W   = 50;
   localparam int REM_W   = 48;
   localparam int Q_W     = 15;
   localparam int DCNT_W  = 2;
   localparam int PULSE_W = 16;

   localparam int HI_LSB      = 17;
   localparam int HI_W        = 30;
   localparam int RECIP_W     = 18;
   localparam int RECIP_SHIFT = 32;

   localparam logic [IDX_W-1:0] REG_START_A  = 3'd0;
   localparam logic [IDX_W-1:0] REG_END_A    = 3'd1;
   localparam logic [IDX_W-1:0] REG_START_B  = 3'd2;
   localparam logic [IDX_W-1:0] REG_END_B    = 3'd3;
   localparam logic [IDX_W-1:0] REG_DURATION = 3'd4;
   localparam logic [IDX_W-1:0] REG_GAIN     = 3'd5;

   localparam logic signed [Y_W-1:0]   X_INIT      = 54'sd33554432;
   localparam logic [REM_W-1:0]        PI_Q30      = 48'd3373259426;
   localparam logic signed [NUM_W-1:0] HALF_PI_Q30 = 50'sd1686629713;
   // floor(2^49 / PI_Q30)
   localparam logic [RECIP_W-1:0]      PI_RECIP    = 18'd166886;

   typedef struct packed {
      logic [ANGLE_W-1:0] start_a;
      logic [ANGLE_W-1:0] end_a;
      logic [ANGLE_W-1:0] start_b;
      logic [ANGLE_W-1:0] end_b;
      logic [DUR_W-1:0]   duration;
      logic [GAIN_W-1:0]  gain;
   } cfg_type;

   typedef struct packed {
      logic clear_time;
      logic load;
      logic mult;
      logic cordic_step;
      logic prod;
      logic div_init;
      logic div_step;
      logic out_load;
      logic advance;
   } cmd_type;

   typedef struct packed {
      logic cordic_done;
      logic div_done;
      logic last;
   } status_type;

   function automatic logic [31:0] atan_q30(input logic [ITER_W-1:0] i);
      logic [31:0] v;
      case (i)
         5'd0:    v = 32'h3243F6A8;
         5'd1:    v = 32'h1DAC6705;
         5'd2:    v = 32'h0FADBAFC;
         5'd3:    v = 32'h07F56EA6;
         5'd4:    v = 32'h03FEAB76;
         5'd5:    v = 32'h01FFD55B;
         5'd6:    v = 32'h00FFFAAA;
         5'd7:    v = 32'h007FFF55;
         5'd8:    v = 32'h003FFFEA;
         5'd9:    v = 32'h001FFFFD;
         5'd10:   v = 32'h000FFFFF;
         5'd11:   v = 32'h0007FFFF;
         5'd12:   v = 32'h0003FFFF;
         5'd13:   v = 32'h0001FFFF;
         5'd14:   v = 32'h0000FFFF;
         5'd15:   v = 32'h00007FFF;
         5'd16:   v = 32'h00003FFF;
         5'd17:   v = 32'h00001FFF;
         5'd18:   v = 32'h00000FFF;
         5'd19:   v = 32'h000007FF;
         5'd20:   v = 32'h000003FF;
         5'd21:   v = 32'h000001FF;
         5'd22:   v = 32'h000000FF;
         5'd23:   v = 32'h0000007F;
         5'd24:   v = 32'h0000003F;
         5'd25:   v = 32'h0000001F;
         5'd26:   v = 32'h0000000F;
         5'd27:   v = 32'h00000008;
         5'd28:   v = 32'h00000004;
         5'd29:   v = 32'h00000002;
         5'd30:   v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

   // 160 * (end - start)
   function automatic logic signed [K_W-1:0] span_gain(input logic [ANGLE_W-1:0] s,
                                                       input logic [ANGLE_W-1:0] e);
      logic signed [ANGLE_W:0] d;
      d = $signed({e[ANGLE_W-1], e}) - $signed({s[ANGLE_W-1], s});
      return $signed({{(K_W-ANGLE_W-1){d[ANGLE_W]}}, d}) * 17'sd160;
   endfunction

   function automatic logic [PULSE_W-1:0] pulse_fn(input logic [ANGLE_W-1:0] s,
                                                   input logic [ANGLE_W-1:0] e,
                                                   input logic [Q_W-1:0] q,
                                                   input logic neg);
      logic signed [18:0] ss;
      logic signed [18:0] es;
      logic signed [18:0] mid;
      logic signed [18:0] ps;
      logic signed [18:0] pe;
      logic signed [18:0] lo;
      logic signed [18:0] hi;
      logic signed [18:0] qs;
      logic signed [18:0] p;
      ss  = $signed({{11{s[ANGLE_W-1]}}, s});
      es  = $signed({{11{e[ANGLE_W-1]}}, e});
      mid = 19'sd22400 + 19'sd80 * (ss + es);
      ps  = 19'sd22400 + 19'sd160 * ss;
      pe  = 19'sd22400 + 19'sd160 * es;
      qs  = $signed({4'b0000, q});
      p   = neg ? (mid - qs) : (mid + qs);
      lo  = (ps < pe) ? ps : pe;
      hi  = (ps < pe) ? pe : ps;
      if (p < lo) begin
         p = lo;
      end
      if (p > hi) begin
         p = hi;
      end
      return p[PULSE_W-1:0];
   endfunction

endpackage

// File: rtl/asmp_regs.sv
// ----------------------------------------------------------------------------
// asmp_regs
// Configuration register bank, written through the csr channel.
// ----------------------------------------------------------------------------
module asmp_regs (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [asmp_pkg::IDX_W-1:0]     csr_index,
   input  logic [asmp_pkg::DATA_W-1:0]    csr_data,
   output asmp_pkg::cfg_type              cfg
);
   import asmp_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_START_A:  cfg_in.start_a  = csr_data[ANGLE_W-1:0];
            REG_END_A:    cfg_in.end_a    = csr_data[ANGLE_W-1:0];
            REG_START_B:  cfg_in.start_b  = csr_data[ANGLE_W-1:0];
            REG_END_B:    cfg_in.end_b    = csr_data[ANGLE_W-1:0];
            REG_DURATION: cfg_in.duration = csr_data[DUR_W-1:0];
            REG_GAIN:     cfg_in.gain     = csr_data[GAIN_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_a  <= 8'd0;
         cfg_ff.end_a    <= 8'd60;
         cfg_ff.start_b  <= 8'd0;
         cfg_ff.end_b    <= 8'd0;
         cfg_ff.duration <= 16'd2000;
         cfg_ff.gain     <= 32'd86059;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: rtl/asmp_ctrl.sv
// ----------------------------------------------------------------------------
// asmp_ctrl
// Sequencer: tick acceptance, move state, datapath commands, result valid.
// ----------------------------------------------------------------------------
module asmp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_restart,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  asmp_pkg::status_type   status,
   output asmp_pkg::cmd_type      cmd
);
   import asmp_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_MULT   = 7'b0000010,
      S_CORDIC = 7'b0000100,
      S_PROD   = 7'b0001000,
      S_DINIT  = 7'b0010000,
      S_DIV    = 7'b0100000,
      S_DONE   = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      moving_ff;
   logic      moving_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      accept;
   logic      out_free;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      moving_in    = moving_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.clear_time = req_restart;
               if (req_restart || moving_ff) begin
                  moving_in = 1'b1;
                  cmd.load  = 1'b1;
                  state_in  = S_MULT;
               end
            end
         end
         S_MULT: begin
            cmd.mult = 1'b1;
            state_in = S_CORDIC;
         end
         S_CORDIC: begin
            cmd.cordic_step = 1'b1;
            if (status.cordic_done) begin
               state_in = S_PROD;
            end
         end
         S_PROD: begin
            cmd.prod = 1'b1;
            state_in = S_DINIT;
         end
         S_DINIT: begin
            cmd.div_init = 1'b1;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               if (status.last) begin
                  moving_in = 1'b0;
               end else begin
                  cmd.advance = 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         moving_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         moving_ff    <= moving_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/asmp_dp.sv
// ----------------------------------------------------------------------------
// asmp_dp
// Datapath: move clock, gain product, CORDIC arctangent, pulse scaling,
// reciprocal division by pi, clamping and result registers.
// ----------------------------------------------------------------------------
module asmp_dp #(
   parameter int STEP_MS      = asmp_pkg::STEP_MS_DEF,
   parameter int CORDIC_STEPS = asmp_pkg::CORDIC_STEPS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  asmp_pkg::cfg_type             cfg,
   input  asmp_pkg::cmd_type             cmd,
   input  logic                          restart,
   output asmp_pkg::status_type          status,
   output logic [asmp_pkg::PULSE_W-1:0]  pulse_a,
   output logic [asmp_pkg::PULSE_W-1:0]  pulse_b,
   output logic                          last
);
   import asmp_pkg::*;

   localparam int NSTEPS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
   localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(NSTEPS - 1);
   localparam logic [DCNT_W-1:0] DIV_EST   = 2'd0;
   localparam logic [DCNT_W-1:0] DIV_REM   = 2'd1;
   localparam logic [DCNT_W-1:0] DIV_FIX   = 2'd2;

   logic [T_W-1:0]            elapsed_ff, elapsed_in;
   logic [T_W-1:0]            t_use;
   logic signed [DIFF_W-1:0]  diff_ff, diff_in;
   logic                      last_ff, last_in;
   logic signed [PROD_W-1:0]  prod_y;
   logic signed [Y_W-1:0]     x_ff, x_in, y_ff, y_in, dx, dy;
   logic signed [Z_W-1:0]     z_ff, z_in, atan_ext;
   logic [ITER_W-1:0]         iter_ff, iter_in;
   logic signed [K_W-1:0]     k_a, k_b;
   logic signed [NUM_W-1:0]   prod_a, prod_b;
   logic signed [NUM_W-1:0]   num_a_ff, num_a_in, num_b_ff, num_b_in;
   logic signed [NUM_W-1:0]   sum_a, sum_b;
   logic [REM_W-1:0]          rem_a_ff, rem_a_in, rem_b_ff, rem_b_in;
   logic [REM_W-1:0]          est_a, est_b, back_a, back_b;
   logic                      neg_a_ff, neg_a_in, neg_b_ff, neg_b_in;
   logic                      ge_a, ge_b;
   logic [Q_W-1:0]            q_a_ff, q_a_in, q_b_ff, q_b_in;
   logic [DCNT_W-1:0]         dcnt_ff, dcnt_in;
   logic [PULSE_W-1:0]        pulse_a_ff, pulse_a_in, pulse_b_ff, pulse_b_in;
   logic                      last_out_ff, last_out_in;

   assign t_use    = restart ? '0 : elapsed_ff;
   assign prod_y   = $signed(cfg.gain) * diff_ff;
   assign dx       = y_ff >>> iter_ff;
   assign dy       = x_ff >>> iter_ff;
   assign atan_ext = $signed({1'b0, atan_q30(iter_ff)});
   assign k_a      = span_gain(cfg.start_a, cfg.end_a);
   assign k_b      = span_gain(cfg.start_b, cfg.end_b);
   assign prod_a   = k_a * z_ff;
   assign prod_b   = k_b * z_ff;
   assign sum_a    = num_a_ff[NUM_W-1] ? (HALF_PI_Q30 - num_a_ff) : (HALF_PI_Q30 + num_a_ff);
   assign sum_b    = num_b_ff[NUM_W-1] ? (HALF_PI_Q30 - num_b_ff) : (HALF_PI_Q30 + num_b_ff);
   assign est_a    = rem_a_ff[HI_LSB +: HI_W] * PI_RECIP;
   assign est_b    = rem_b_ff[HI_LSB +: HI_W] * PI_RECIP;
   assign back_a   = q_a_ff * PI_Q30;
   assign back_b   = q_b_ff * PI_Q30;
   assign ge_a     = (rem_a_ff >= PI_Q30);
   assign ge_b     = (rem_b_ff >= PI_Q30);

   assign status.cordic_done = (iter_ff == LAST_ITER);
   assign status.div_done    = (dcnt_ff == DIV_FIX);
   assign status.last        = last_ff;

   assign pulse_a = pulse_a_ff;
   assign pulse_b = pulse_b_ff;
   assign last    = last_out_ff;

   always_comb begin
      elapsed_in  = elapsed_ff;
      diff_in     = diff_ff;
      last_in     = last_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      z_in        = z_ff;
      iter_in     = iter_ff;
      num_a_in    = num_a_ff;
      num_b_in    = num_b_ff;
      rem_a_in    = rem_a_ff;
      rem_b_in    = rem_b_ff;
      neg_a_in    = neg_a_ff;
      neg_b_in    = neg_b_ff;
      q_a_in      = q_a_ff;
      q_b_in      = q_b_ff;
      dcnt_in     = dcnt_ff;
      pulse_a_in  = pulse_a_ff;
      pulse_b_in  = pulse_b_ff;
      last_out_in = last_out_ff;

      if (cmd.clear_time) begin
         elapsed_in = '0;
      end
      if (cmd.load) begin
         diff_in = $signed({2'b00, t_use, 1'b0}) - $signed({4'b0000, cfg.duration});
         last_in = ({1'b0, t_use} + (T_W+1)'(STEP_MS)) > {2'b00, cfg.duration};
      end
      if (cmd.mult) begin
         y_in    = {{(Y_W-PROD_W){prod_y[PROD_W-1]}}, prod_y};
         x_in    = X_INIT;
         z_in    = '0;
         iter_in = '0;
      end
      if (cmd.cordic_step) begin
         iter_in = iter_ff + 1'b1;
         if (!y_ff[Y_W-1] && (y_ff != '0)) begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + atan_ext;
         end else if (y_ff[Y_W-1]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - atan_ext;
         end
      end
      if (cmd.prod) begin
         num_a_in = prod_a;
         num_b_in = prod_b;
      end
      if (cmd.div_init) begin
         rem_a_in = sum_a[REM_W-1:0];
         rem_b_in = sum_b[REM_W-1:0];
         neg_a_in = num_a_ff[NUM_W-1];
         neg_b_in = num_b_ff[NUM_W-1];
         q_a_in   = '0;
         q_b_in   = '0;
         dcnt_in  = '0;
      end
      if (cmd.div_step) begin
         case (dcnt_ff)
            DIV_EST: begin
               q_a_in = est_a[RECIP_SHIFT +: Q_W];
               q_b_in = est_b[RECIP_SHIFT +: Q_W];
            end
            DIV_REM: begin
               rem_a_in = rem_a_ff - back_a;
               rem_b_in = rem_b_ff - back_b;
            end
            DIV_FIX: begin
               if (ge_a) begin
                  q_a_in = q_a_ff + 1'b1;
               end
               if (ge_b) begin
                  q_b_in = q_b_ff + 1'b1;
               end
            end
            default: begin
               q_a_in = q_a_ff;
            end
         endcase
         dcnt_in = dcnt_ff + 1'b1;
      end
      if (cmd.out_load) begin
         pulse_a_in  = pulse_fn(cfg.start_a, cfg.end_a, q_a_ff, neg_a_ff);
         pulse_b_in  = pulse_fn(cfg.start_b, cfg.end_b, q_b_ff, neg_b_ff);
         last_out_in = last_ff;
      end
      if (cmd.advance) begin
         elapsed_in = elapsed_ff + T_W'(STEP_MS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff <= '0;
      end else begin
         elapsed_ff <= elapsed_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff     <= diff_in;
      last_ff     <= last_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      z_ff        <= z_in;
      iter_ff     <= iter_in;
      num_a_ff    <= num_a_in;
      num_b_ff    <= num_b_in;
      rem_a_ff    <= rem_a_in;
      rem_b_ff    <= rem_b_in;
      neg_a_ff    <= neg_a_in;
      neg_b_ff    <= neg_b_in;
      q_a_ff      <= q_a_in;
      q_b_ff      <= q_b_in;
      dcnt_ff     <= dcnt_in;
      pulse_a_ff  <= pulse_a_in;
      pulse_b_ff  <= pulse_b_in;
      last_out_ff <= last_out_in;
   end

endmodule

// File: rtl/arctan_servo_motion_profile_core.sv
// ----------------------------------------------------------------------------
// arctan_servo_motion_profile_core
// Two-servo arctangent S-curve set point generator, one transaction per tick.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/stall     req_restart
//   rsp      out        rsp_valid/stall     rsp_pulse_a, rsp_pulse_b, rsp_last
//   csr      in         csr_valid/ready     csr_index, csr_data
//
// A tick that produces a result goes from accept to result register through
// a gain product, min(CORDIC_STEPS, 32) CORDIC iterations at one iteration per
// cycle, a scaling step, reciprocal division by pi (set-up, estimate,
// remainder, one correction) and an output load. The next tick is taken in
// the cycle after the output load. An idle tick starts no computation.
// Reset is synchronous; no clearing pass. The next tick is accepted while a
// result waits in the output register under rsp_stall.
// ----------------------------------------------------------------------------
module arctan_servo_motion_profile_core #(
   parameter int STEP_MS      = asmp_pkg::STEP_MS_DEF,
   parameter int CORDIC_STEPS = asmp_pkg::CORDIC_STEPS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_restart,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [asmp_pkg::PULSE_W-1:0]  rsp_pulse_a,
   output logic [asmp_pkg::PULSE_W-1:0]  rsp_pulse_b,
   output logic                          rsp_last,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [asmp_pkg::IDX_W-1:0]    csr_index,
   input  logic [asmp_pkg::DATA_W-1:0]   csr_data
);
   import asmp_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   asmp_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   asmp_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_restart (req_restart),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .status      (status),
      .cmd         (cmd)
   );

   asmp_dp #(
      .STEP_MS      (STEP_MS),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_dp (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .cmd     (cmd),
      .restart (req_restart),
      .status  (status),
      .pulse_a (rsp_pulse_a),
      .pulse_b (rsp_pulse_b),
      .last    (rsp_last)
   );

endmodule

// File: rtl/asmp_check.sv
// ----------------------------------------------------------------------------
// asmp_check
// Port-level checks of the motion profile core, bound to the top level.
// ----------------------------------------------------------------------------
module asmp_check (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          req_restart,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [asmp_pkg::PULSE_W-1:0]  rsp_pulse_a,
   input logic [asmp_pkg::PULSE_W-1:0]  rsp_pulse_b,
   input logic                          rsp_last
);
   import asmp_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pulse_a)
                                 && $stable(rsp_pulse_b) && $stable(rsp_last))
      else $error("stalled result transaction changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_pulse_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pulse_a >= 16'd1920 && rsp_pulse_a <= 16'd42720
                 && rsp_pulse_b >= 16'd1920 && rsp_pulse_b <= 16'd42720)
      else $error("pulse outside servo span");

   a_restart_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_restart |=> req_stall)
      else $error("restart transaction did not start a computation");

endmodule

bind arctan_servo_motion_profile_core asmp_check u_check (.*);
